FILE: rtl/kdeb_pkg.sv
// Shared types and constants for the eager-press, deferred-release key debouncer.
// Holds the per-key table entry layout, the mode encoding and the table sizes.
// No dependencies.
package kdeb_pkg;

  localparam int NUM_KEYS  = 128;
  localparam int KEY_AW    = 7;
  localparam int KEY_CNT_W = KEY_AW + 1;
  localparam int TICK_W    = 32;
  localparam int DBNC_W    = 16;

  localparam logic [DBNC_W-1:0] DBNC_RESET = 16'd5;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_EAGER     = 2'd1,
    MODE_DEFER_REL = 2'd2,
    MODE_DEFER_PRS = 2'd3
  } key_mode_t;

  typedef struct packed {
    key_mode_t         mode;
    logic [TICK_W-1:0] stamp;
    logic              reported;
  } key_entry_t;

endpackage

FILE: rtl/kdeb_key_ram.sv
// Per-key state table: synchronous memory with one read and one write port.
// Entries never written since reset read as all zero through flip-flop valid bits.
// Depends on kdeb_pkg.
module kdeb_key_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [kdeb_pkg::KEY_AW-1:0] rd_addr,
  output kdeb_pkg::key_entry_t        rd_data,
  input  logic                       wr_en,
  input  logic [kdeb_pkg::KEY_AW-1:0] wr_addr,
  input  kdeb_pkg::key_entry_t        wr_data
);

  kdeb_pkg::key_entry_t mem [kdeb_pkg::NUM_KEYS];
  logic [kdeb_pkg::NUM_KEYS-1:0] valid_r;
  kdeb_pkg::key_entry_t rd_mem_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry that has never been written holds its reset value: idle, stamp zero, released.
  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

FILE: rtl/key_debounce_eager_press_defer_release.sv
// Top level of the eager-press, deferred-release key debouncer.
// Instantiates kdeb_key_ram; uses kdeb_pkg for types and constants.
//
// Each accepted key sample gives exactly one result beat through the output register.
// The sample's key entry (mode, 32-bit stamp, reported level) is read from a
// one-port-read, one-port-write table when the sample is accepted, and is updated and
// written back when it leaves the s1 stage; a write-back register forwards the entry
// when the same key follows directly, so consecutive samples of one key need no bubble.
// Throughput is set by that single read-modify-write of the table: one sample per
// cycle while the result side takes beats. No clearing pass is needed after reset.
module key_debounce_eager_press_defer_release (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: debounce_ticks
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Input samples
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [6:0] key_index, [7] raw_level, [39:8] now_tick
  input  logic        in_tlast,   // last_of_scan
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [6:0] key_number, [7] debounced_level,
                                  // [8] level_changed, [9] scan_changed, rest zero
);

  localparam int AW = kdeb_pkg::KEY_AW;
  localparam int TW = kdeb_pkg::TICK_W;

  logic [kdeb_pkg::DBNC_W-1:0] dbnc_r;

  logic          s1_valid_r;
  logic [AW-1:0] s1_idx_r;
  logic          s1_raw_r;
  logic [TW-1:0] s1_now_r;
  logic          s1_last_r;

  logic                 wb_valid_r;
  logic [AW-1:0]        wb_idx_r;
  kdeb_pkg::key_entry_t wb_data_r;

  logic scan_acc_r;
  logic scan_acc_nxt;

  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [15:0] out_data_nxt;

  logic                 in_go;
  logic                 s1_go;
  logic                 in_range;
  logic                 wr_en;
  kdeb_pkg::key_entry_t ram_rd;
  kdeb_pkg::key_entry_t cur;
  kdeb_pkg::key_entry_t upd;
  logic                 changed;
  logic                 level;
  logic                 scan_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbnc_r <= kdeb_pkg::DBNC_RESET;
    end else if (cfg_valid) begin
      dbnc_r <= cfg_data;
    end
  end

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_go     = in_tvalid && in_tready;

  kdeb_key_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_go),
    .rd_addr (in_tdata[AW-1:0]),
    .rd_data (ram_rd),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_go) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_idx_r  <= in_tdata[AW-1:0];
      s1_raw_r  <= in_tdata[7];
      s1_now_r  <= in_tdata[39:8];
      s1_last_r <= in_tlast;
    end
  end

  // The table read lands at the same edge as the previous write-back, so the
  // write-back register holds the newest copy of that key.
  assign cur = (wb_valid_r && (wb_idx_r == s1_idx_r)) ? wb_data_r : ram_rd;

  assign in_range = {1'b0, s1_idx_r} < kdeb_pkg::KEY_CNT_W'(kdeb_pkg::NUM_KEYS);

  always_comb begin
    logic [TW-1:0] elapsed;
    logic          settled;
    upd = cur;
    if ((upd.mode == kdeb_pkg::MODE_IDLE) && (s1_raw_r != upd.reported)) begin
      upd.mode  = s1_raw_r ? kdeb_pkg::MODE_EAGER : kdeb_pkg::MODE_DEFER_REL;
      upd.stamp = s1_now_r;
      if (s1_raw_r) begin
        upd.reported = 1'b1;
      end
    end
    // A bounce in a deferred mode follows the raw level and restarts the timer.
    if ((upd.mode == kdeb_pkg::MODE_DEFER_REL) || (upd.mode == kdeb_pkg::MODE_DEFER_PRS)) begin
      if (s1_raw_r != (upd.mode == kdeb_pkg::MODE_DEFER_PRS)) begin
        upd.mode  = s1_raw_r ? kdeb_pkg::MODE_DEFER_PRS : kdeb_pkg::MODE_DEFER_REL;
        upd.stamp = s1_now_r;
      end
    end
    elapsed = s1_now_r - upd.stamp;
    settled = elapsed >= {{(TW-kdeb_pkg::DBNC_W){1'b0}}, dbnc_r};
    if ((upd.mode != kdeb_pkg::MODE_IDLE) && settled) begin
      upd.mode = kdeb_pkg::MODE_IDLE;
      if (!s1_raw_r) begin
        upd.reported = 1'b0;
      end
    end
  end

  assign wr_en   = s1_go && in_range;
  assign level   = in_range ? upd.reported : 1'b0;
  assign changed = in_range ? (upd.reported ^ cur.reported) : 1'b0;

  always_comb begin
    scan_out     = 1'b0;
    scan_acc_nxt = scan_acc_r | changed;
    if (s1_last_r) begin
      scan_out     = scan_acc_r | changed;
      scan_acc_nxt = 1'b0;
    end
  end

  assign out_data_nxt = {6'd0, scan_out, changed, level, s1_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r  <= 1'b0;
      scan_acc_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        wb_valid_r <= 1'b1;
      end
      if (s1_go) begin
        scan_acc_r  <= scan_acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_idx_r  <= s1_idx_r;
      wb_data_r <= upd;
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
